// ===== hdl/als_pkg.sv =====
// ----------------------------------------------------------------------------
// als_pkg - addressable LED serializer package
// Shared widths, codes, reset values and types for the LED strip serializer.
// ----------------------------------------------------------------------------
package als_pkg;

  localparam int unsigned MaxPixels    = 256;
  localparam int unsigned PixAddrW     = $clog2(MaxPixels);
  localparam int unsigned ColorW       = 24;
  localparam int unsigned BitsPerPixel = 24;
  localparam int unsigned BitCntW      = $clog2(BitsPerPixel);
  localparam int unsigned RegW         = 8;
  localparam int unsigned CfgIdxW      = 3;

  localparam logic [BitCntW-1:0] LastBit = BitCntW'(BitsPerPixel - 1);

  typedef enum logic [1:0] {
    OP_SET_PIXEL = 2'd0,
    OP_SET_ALL   = 2'd1,
    OP_SHOW      = 2'd2,
    OP_TICK      = 2'd3
  } opcode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PIXEL_COUNT = 3'd0,
    CFG_ONE_HIGH    = 3'd1,
    CFG_ONE_LOW     = 3'd2,
    CFG_ZERO_HIGH   = 3'd3,
    CFG_ZERO_LOW    = 3'd4
  } cfg_idx_e;

  typedef enum logic {
    ST_RUN,
    ST_FILL
  } ctrl_state_e;

  typedef struct packed {
    logic [RegW-1:0] pixel_count;
    logic [RegW-1:0] one_high;
    logic [RegW-1:0] one_low;
    logic [RegW-1:0] zero_high;
    logic [RegW-1:0] zero_low;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    pixel_count: 8'd0,
    one_high:    8'd38,
    one_low:     8'd5,
    zero_high:   8'd17,
    zero_low:    8'd10
  };

  typedef struct packed {
    logic sending;
    logic in_low;
    logic last;
  } tx_status_t;

endpackage

// ===== hdl/als_if.sv =====
// ----------------------------------------------------------------------------
// als_in_if / als_out_if - command and result channels
// Valid/ready channels carrying the serializer's commands and line results.
// ----------------------------------------------------------------------------
interface als_in_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       opcode;
  logic [als_pkg::PixAddrW-1:0]     pixel_index;
  logic [als_pkg::ColorW-1:0]       color;

  modport source (output valid, output opcode, output pixel_index, output color,
                  input ready);
  modport sink   (input valid, input opcode, input pixel_index, input color,
                  output ready);
endinterface

interface als_out_if;
  logic valid;
  logic ready;
  logic line_out;
  logic busy_res;
  logic frame_done;

  modport source (output valid, output line_out, output busy_res, output frame_done,
                  input ready);
  modport sink   (input valid, input line_out, input busy_res, input frame_done,
                  output ready);
endinterface

// ===== hdl/als_store.sv =====
// ----------------------------------------------------------------------------
// als_store - pixel colour store
// One write and one registered read per cycle; entries never written read as
// zero through per-entry valid bits cleared at reset.
// ----------------------------------------------------------------------------
module als_store (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               we_i,
  input  logic [als_pkg::PixAddrW-1:0]       waddr_i,
  input  logic [als_pkg::ColorW-1:0]         wdata_i,
  input  logic [als_pkg::PixAddrW-1:0]       raddr_i,
  output logic [als_pkg::ColorW-1:0]         rdata_o
);

  logic [als_pkg::ColorW-1:0]    mem [als_pkg::MaxPixels];
  logic [als_pkg::MaxPixels-1:0] valid_q;
  logic [als_pkg::ColorW-1:0]    rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (we_i) begin
      valid_q[waddr_i] <= 1'b1;
    end
  end

  // write-first on an address collision
  always_ff @(posedge clk_i) begin
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_q <= wdata_i;
    end else if (valid_q[raddr_i]) begin
      rdata_q <= mem[raddr_i];
    end else begin
      rdata_q <= '0;
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/als_tx.sv =====
// ----------------------------------------------------------------------------
// als_tx - bit serializer
// Shifts the current pixel out MSB first in GRB order, timing each bit's
// high and low phase with a tick counter.
// ----------------------------------------------------------------------------
module als_tx (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  als_pkg::cfg_t                      cfg_i,
  input  logic                               start_i,
  input  logic                               tick_i,
  input  logic [als_pkg::ColorW-1:0]         rdata_i,
  output logic [als_pkg::PixAddrW-1:0]       raddr_o,
  output als_pkg::tx_status_t                status_o
);

  logic                             sending_q, sending_d;
  logic                             in_low_q, in_low_d;
  logic [als_pkg::RegW-1:0]         pt_q, pt_d;
  logic [als_pkg::BitCntW-1:0]      bit_q, bit_d;
  logic [als_pkg::PixAddrW-1:0]     pix_q, pix_d;
  logic [als_pkg::ColorW-1:0]       sr_q, sr_d;

  logic                             cur_bit;
  logic [als_pkg::RegW-1:0]         len;
  logic [als_pkg::RegW-1:0]         pt_inc;
  logic [als_pkg::PixAddrW-1:0]     pix_inc;
  logic                             phase_end;
  logic                             frame_end;
  logic [als_pkg::ColorW-1:0]       grb;

  assign grb     = {rdata_i[15:8], rdata_i[23:16], rdata_i[7:0]};
  assign cur_bit = sr_q[als_pkg::ColorW-1];
  assign pt_inc  = pt_q + 1'b1;
  assign pix_inc = pix_q + 1'b1;

  always_comb begin
    if (in_low_q) begin
      len = cur_bit ? cfg_i.one_low : cfg_i.zero_low;
    end else begin
      len = cur_bit ? cfg_i.one_high : cfg_i.zero_high;
    end
  end

  // a zero length behaves as one tick
  assign phase_end = (pt_inc >= len) || (pt_inc == '0);
  assign frame_end = (pix_inc >= cfg_i.pixel_count) || (pix_inc == '0);

  // prefetch the next pixel while the current one is on the line; pixel 0
  // is read back as soon as the frame ends, ready for an immediate show
  assign raddr_o = sending_d ? pix_inc : '0;

  always_comb begin
    sending_d = sending_q;
    in_low_d  = in_low_q;
    pt_d      = pt_q;
    bit_d     = bit_q;
    pix_d     = pix_q;
    sr_d      = sr_q;
    if (start_i) begin
      sending_d = 1'b1;
      in_low_d  = 1'b0;
      pt_d      = '0;
      bit_d     = '0;
      pix_d     = '0;
      sr_d      = grb;
    end else if (tick_i) begin
      pt_d = phase_end ? '0 : pt_inc;
      if (phase_end) begin
        if (!in_low_q) begin
          in_low_d = 1'b1;
        end else begin
          in_low_d = 1'b0;
          if (bit_q == als_pkg::LastBit) begin
            bit_d = '0;
            if (frame_end) begin
              sending_d = 1'b0;
              pix_d     = '0;
            end else begin
              pix_d = pix_inc;
              sr_d  = grb;
            end
          end else begin
            bit_d = bit_q + 1'b1;
            sr_d  = {sr_q[als_pkg::ColorW-2:0], 1'b0};
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sending_q <= 1'b0;
      in_low_q  <= 1'b0;
      pt_q      <= '0;
      bit_q     <= '0;
      pix_q     <= '0;
    end else begin
      sending_q <= sending_d;
      in_low_q  <= in_low_d;
      pt_q      <= pt_d;
      bit_q     <= bit_d;
      pix_q     <= pix_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sr_q <= sr_d;
  end

  assign status_o.sending = sending_q;
  assign status_o.in_low  = in_low_q;
  assign status_o.last    = sending_q && in_low_q && phase_end &&
                            (bit_q == als_pkg::LastBit) && frame_end;

endmodule

// ===== hdl/addressable_led_serializer.sv =====
// ----------------------------------------------------------------------------
// addressable_led_serializer - single-wire LED strip driver
// Pixel store, fill sequencer, serializer and result register.
// ----------------------------------------------------------------------------
// Every command transaction yields one result transaction. Set-pixel, show
// and tick are acted on as they are accepted, so one command per clock is
// sustained while the result side keeps up; a one-entry result register lets
// the next command in on the cycle the waiting result is taken. Set-all
// answers at once and then fills the store one entry per cycle, holding off
// commands until entries 0 to pixel_count-1 are written, as the store has a
// single write port. The store clears at reset via per-entry valid bits, with
// no clearing pass. Each tick advances the line by one phase tick; the next
// pixel is fetched during the current one, so pixel boundaries add no gap.
module addressable_led_serializer (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [als_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [als_pkg::RegW-1:0]           cfg_data_i,
  als_in_if.sink                             in_if,
  als_out_if.source                          out_if
);

  als_pkg::cfg_t                    cfg_q;
  als_pkg::ctrl_state_e             state_q, state_d;
  logic [als_pkg::PixAddrW-1:0]     fill_cnt_q, fill_cnt_d;
  logic [als_pkg::ColorW-1:0]       fill_color_q;
  logic                             out_valid_q;
  logic                             line_q, busy_q, done_q;

  als_pkg::tx_status_t              tx_status;
  logic [als_pkg::PixAddrW-1:0]     raddr;
  logic [als_pkg::ColorW-1:0]       rdata;

  logic                             accept;
  logic                             idle_ok;
  logic                             start;
  logic                             tick;
  logic                             set_pixel;
  logic                             set_all;
  logic                             fill_last;
  logic                             we;
  logic [als_pkg::PixAddrW-1:0]     waddr;
  logic [als_pkg::ColorW-1:0]       wdata;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= als_pkg::CfgReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        als_pkg::CFG_PIXEL_COUNT: cfg_q.pixel_count <= cfg_data_i;
        als_pkg::CFG_ONE_HIGH:    cfg_q.one_high    <= cfg_data_i;
        als_pkg::CFG_ONE_LOW:     cfg_q.one_low     <= cfg_data_i;
        als_pkg::CFG_ZERO_HIGH:   cfg_q.zero_high   <= cfg_data_i;
        als_pkg::CFG_ZERO_LOW:    cfg_q.zero_low    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_if.ready = (state_q == als_pkg::ST_RUN) && (!out_valid_q || out_if.ready);
  assign accept      = in_if.valid && in_if.ready;
  assign idle_ok     = accept && !tx_status.sending;

  assign start     = idle_ok && (in_if.opcode == als_pkg::OP_SHOW) &&
                     (cfg_q.pixel_count != '0);
  assign tick      = accept && tx_status.sending && (in_if.opcode == als_pkg::OP_TICK);
  assign set_pixel = idle_ok && (in_if.opcode == als_pkg::OP_SET_PIXEL) &&
                     (in_if.pixel_index < cfg_q.pixel_count);
  assign set_all   = idle_ok && (in_if.opcode == als_pkg::OP_SET_ALL) &&
                     (cfg_q.pixel_count != '0);
  assign fill_last = fill_cnt_q == (cfg_q.pixel_count - 1'b1);

  // fill sequencer: next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      als_pkg::ST_RUN:  if (set_all) state_d = als_pkg::ST_FILL;
      als_pkg::ST_FILL: if (fill_last) state_d = als_pkg::ST_RUN;
      default:          state_d = als_pkg::ST_RUN;
    endcase
  end

  // fill sequencer: outputs
  always_comb begin
    we         = set_pixel;
    waddr      = in_if.pixel_index;
    wdata      = in_if.color;
    fill_cnt_d = '0;
    unique case (state_q)
      als_pkg::ST_RUN: ;
      als_pkg::ST_FILL: begin
        we         = 1'b1;
        waddr      = fill_cnt_q;
        wdata      = fill_color_q;
        fill_cnt_d = fill_cnt_q + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= als_pkg::ST_RUN;
      fill_cnt_q <= '0;
    end else begin
      state_q    <= state_d;
      fill_cnt_q <= fill_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (set_all) begin
      fill_color_q <= in_if.color;
    end
  end

  als_store u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  als_tx u_tx (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .start_i  (start),
    .tick_i   (tick),
    .rdata_i  (rdata),
    .raddr_o  (raddr),
    .status_o (tx_status)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // a started frame shows its first high phase straight away
  always_ff @(posedge clk_i) begin
    if (accept) begin
      line_q <= start || (tx_status.sending && !tx_status.in_low);
      busy_q <= start || tx_status.sending;
      done_q <= (in_if.opcode == als_pkg::OP_TICK) && tx_status.last;
    end
  end

  assign out_if.valid      = out_valid_q;
  assign out_if.line_out   = line_q;
  assign out_if.busy_res   = busy_q;
  assign out_if.frame_done = done_q;

endmodule
